>>> hdl/csm_pkg.sv
// ----------------------------------------------------------------------------
// csm_pkg
// shared codes and constants for the convex support mapping block
// ----------------------------------------------------------------------------
package csm_pkg;
  localparam int FIELD_W = 16;
  localparam int MARGIN_W = 10;
  localparam int COUNT_W = 7;
  localparam int SLOT_W = 6;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef enum logic {
    REG_MARGIN = 1'b0,
    REG_COUNT  = 1'b1
  } reg_idx_t;

  // request from sequencer to the sqrt and divide units
  typedef struct packed {
    logic start;
    logic sqrt_mode;
  } ctl_t;
endpackage

>>> hdl/convex_support_mapping.sv
// ----------------------------------------------------------------------------
// convex_support_mapping
// support point of a stored vertex hull along a direction, plus margin
// ----------------------------------------------------------------------------
// channel | dir | handshake          | content
// in      | in  | in_tvalid/tready   | op (tuser), slot, x, y, z (tdata)
// out     | out | out_tvalid/tready  | sup xyz, best_index (tdata); flags (tuser)
// cfg     | in  | cfg_valid/ready    | register index, write data
//
// a load writes one vertex. a query holds the input while it scans the
// vertices in use through the one memory read port, fetches the winner, takes
// one square root of the direction length, runs the shared divider per axis
// and clamps; a zero direction skips root and divider, and no vertex in use
// goes straight to the output stage. reset is synchronous and clears control
// and configuration only; the vertex memory is not cleared. one item at a
// time; the clamp stage waits while an earlier result is still unclaimed.
module convex_support_mapping import csm_pkg::*; #(
  parameter int MAX_VERTICES = 64,
  parameter int COORD_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // slot[5:0], x[21:6], y[37:22], z[53:38]
  input  logic        in_tuser,   // op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // sup_x[15:0], sup_y, sup_z, best_index[53:48]
  output logic [1:0]  out_tuser,  // empty_shape, clipped
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [9:0]  cfg_data
);
  localparam int AW = $clog2(MAX_VERTICES);
  localparam int CB = COORD_BITS;
  localparam int DOT_W = 2 * CB + 2;
  localparam int SQ_W = 2 * CB + 2;
  localparam int RT_W = CB + 1;
  localparam int NUM_W = CB + MARGIN_W;
  localparam int RES_W = CB + 2;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_FETCH, S_SQRT, S_DIV, S_OUT
  } state_t;

  state_t state_r;
  logic [MARGIN_W-1:0] margin_r;
  logic [COUNT_W-1:0]  count_r;
  logic signed [CB-1:0] d_r [3];
  logic [AW:0]  ridx_r;       // next address issued
  logic [AW:0]  cidx_r;       // index of data on the read port
  logic         rv_r;         // read data valid
  logic signed [DOT_W-1:0] best_dot_r;
  logic [AW-1:0] best_r;
  logic signed [RES_W-1:0] res_r [3];
  logic [1:0]   axis_r;
  logic [RT_W-1:0] len_r;
  logic         empty_r;
  logic [55:0]  odata_r;
  logic [1:0]   ouser_r;
  logic         ovalid_r;
  logic [SQ_W-1:0] sq_r;
  ctl_t         ctl;

  // coordinate extraction, sign extended from bit FIELD_W-1 of each field
  logic signed [CB-1:0] cx, cy, cz;
  assign cx = CB'($signed(in_tdata[6 +: FIELD_W]));
  assign cy = CB'($signed(in_tdata[22 +: FIELD_W]));
  assign cz = CB'($signed(in_tdata[38 +: FIELD_W]));

  logic [SLOT_W-1:0] slot;
  assign slot = in_tdata[SLOT_W-1:0];

  logic [AW:0] n_eff;
  assign n_eff = (int'(count_r) > MAX_VERTICES) ?
                 (AW+1)'(MAX_VERTICES) : (AW+1)'(count_r);

  logic in_acc;
  assign in_tready = (state_r == S_IDLE);
  assign in_acc = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // vertex memory
  logic we;
  logic [3*CB-1:0] rdata;
  logic signed [CB-1:0] vx, vy, vz;
  assign we = in_acc && (in_tuser == OP_LOAD) && (int'(slot) < MAX_VERTICES);
  logic [AW-1:0] raddr;
  assign raddr = (state_r == S_FETCH) ? best_r : ridx_r[AW-1:0];

  csm_vstore #(.DEPTH(MAX_VERTICES), .W(3*CB)) u_store (
    .clk(clk), .we(we), .waddr(AW'(slot)), .wdata({cz, cy, cx}),
    .raddr(raddr), .rdata(rdata)
  );
  assign vx = rdata[CB-1:0];
  assign vy = rdata[2*CB-1:CB];
  assign vz = rdata[3*CB-1:2*CB];

  // one dot product per cycle of the scan
  logic signed [2*CB-1:0] prod [3];
  assign prod[0] = vx * d_r[0];
  assign prod[1] = vy * d_r[1];
  assign prod[2] = vz * d_r[2];
  logic signed [DOT_W-1:0] dot;
  assign dot = DOT_W'(prod[0]) + DOT_W'(prod[1]) + DOT_W'(prod[2]);

  // square of direction length, three products summed over the scan
  logic [CB-1:0] amag [3];
  always_comb begin
    for (int k = 0; k < 3; k++)
      amag[k] = d_r[k][CB-1] ? CB'(-d_r[k]) : CB'(d_r[k]);
  end

  logic [2*CB-1:0] asq [3];
  always_comb begin
    for (int k = 0; k < 3; k++)
      asq[k] = amag[k] * amag[k];
  end

  // shared iterative units
  logic sq_done, dv_done;
  logic [RT_W-1:0] root;
  logic [NUM_W-1:0] quot;
  logic [NUM_W-1:0] numer;
  assign numer = NUM_W'(margin_r) * NUM_W'(amag[axis_r]);

  csm_isqrt #(.IN_W(SQ_W), .OUT_W(RT_W)) u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(ctl.start && ctl.sqrt_mode),
    .radicand(sq_r), .done(sq_done), .root(root)
  );
  csm_div #(.N_W(NUM_W), .D_W(RT_W)) u_div (
    .clk(clk), .rst_n(rst_n), .start(ctl.start && !ctl.sqrt_mode),
    .numer(numer), .denom(len_r), .done(dv_done), .quot(quot)
  );

  logic dir_nz;
  assign dir_nz = (d_r[0] != '0) || (d_r[1] != '0) || (d_r[2] != '0);

  logic signed [RES_W-1:0] hi, lo;
  assign hi = RES_W'((1 << (CB-1)) - 1);
  assign lo = -hi - RES_W'(1);

  logic div_busy_r;

  always_comb begin
    ctl.start = 1'b0;
    ctl.sqrt_mode = 1'b0;
    if (state_r == S_FETCH && rv_r && dir_nz) begin
      ctl.start = 1'b1;
      ctl.sqrt_mode = 1'b1;
    end else if (state_r == S_DIV && !div_busy_r) begin
      ctl.start = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      margin_r   <= MARGIN_W'(20);
      count_r    <= '0;
      ovalid_r   <= 1'b0;
      rv_r       <= 1'b0;
      div_busy_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_MARGIN: margin_r <= cfg_data;
          REG_COUNT:  count_r  <= cfg_data[COUNT_W-1:0];
        endcase
      end
      if (ovalid_r && out_tready) ovalid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_acc && in_tuser == OP_QUERY) begin
            d_r[0] <= cx;
            d_r[1] <= cy;
            d_r[2] <= cz;
            ridx_r <= '0;
            rv_r   <= 1'b0;
            // no vertex in use: straight to the output stage
            empty_r <= (n_eff == '0);
            state_r <= (n_eff == '0) ? S_OUT : S_SCAN;
          end
        end
        S_SCAN: begin
          sq_r <= SQ_W'(asq[0]) + SQ_W'(asq[1]) + SQ_W'(asq[2]);
          if (ridx_r < n_eff) begin
            ridx_r <= ridx_r + 1'b1;
            cidx_r <= ridx_r;
            rv_r   <= 1'b1;
          end else begin
            rv_r <= 1'b0;
          end
          if (rv_r) begin
            if (cidx_r == '0 || dot > best_dot_r) begin
              best_dot_r <= dot;
              best_r     <= cidx_r[AW-1:0];
            end
          end
          if (rv_r && (cidx_r + 1'b1 == n_eff)) begin
            state_r <= S_FETCH;
          end
        end
        S_FETCH: begin
          // the read of the winner is issued while rv_r is low, the vertex is captured once rv_r is set
          if (!rv_r) begin
            rv_r <= 1'b1;
          end else begin
            rv_r <= 1'b0;
            res_r[0] <= RES_W'(vx);
            res_r[1] <= RES_W'(vy);
            res_r[2] <= RES_W'(vz);
            axis_r   <= '0;
            state_r  <= dir_nz ? S_SQRT : S_OUT;
          end
        end
        S_SQRT: begin
          if (sq_done) begin
            len_r   <= root;
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (!div_busy_r) begin
            div_busy_r <= 1'b1;
          end else if (dv_done) begin
            div_busy_r <= 1'b0;
            res_r[axis_r] <= d_r[axis_r][CB-1] ?
                             res_r[axis_r] - RES_W'(quot) :
                             res_r[axis_r] + RES_W'(quot);
            if (axis_r == 2'd2) state_r <= S_OUT;
            else axis_r <= axis_r + 1'b1;
          end
        end
        S_OUT: begin
          logic signed [RES_W-1:0] cl [3];
          logic c;
          c = 1'b0;
          for (int k = 0; k < 3; k++) begin
            cl[k] = res_r[k];
            if (res_r[k] > hi) begin cl[k] = hi; c = 1'b1; end
            else if (res_r[k] < lo) begin cl[k] = lo; c = 1'b1; end
          end
          // wait here while an earlier result is still unclaimed
          if (!ovalid_r) begin
            if (empty_r) begin
              odata_r <= '0;
              ouser_r <= 2'b01;
            end else begin
              odata_r <= {2'b00, SLOT_W'(best_r), FIELD_W'(cl[2]),
                          FIELD_W'(cl[1]), FIELD_W'(cl[0])};
              ouser_r <= {c, 1'b0};
            end
            ovalid_r <= 1'b1;
            state_r  <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;
  assign out_tuser  = ouser_r;
endmodule

>>> hdl/csm_isqrt.sv
// ----------------------------------------------------------------------------
// csm_isqrt
// iterative integer square root, one result bit per cycle
// ----------------------------------------------------------------------------
module csm_isqrt import csm_pkg::*; #(
  parameter int IN_W = 34,
  parameter int OUT_W = 17
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [IN_W-1:0]  radicand,
  output logic             done,
  output logic [OUT_W-1:0] root
);
  localparam int RW = 2 * OUT_W;
  localparam int CW = $clog2(OUT_W + 1);
  logic [RW-1:0]     rem_r;
  logic [RW-1:0]     num_r;
  logic [OUT_W-1:0]  root_r;
  logic [CW-1:0]     cnt_r;
  logic              busy_r, done_r;
  logic [RW+1:0]     trial;
  logic [RW+1:0]     rem_sh;

  always_comb begin
    rem_sh = {rem_r, num_r[RW-1 -: 2]};
    trial  = rem_sh - {{(RW+2-OUT_W-2){1'b0}}, root_r, 2'b01};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        rem_r  <= '0;
        root_r <= '0;
        num_r  <= RW'(radicand);
        cnt_r  <= CW'(OUT_W);
      end else if (busy_r) begin
        num_r <= num_r << 2;
        if (!trial[RW+1]) begin
          rem_r  <= trial[RW-1:0];
          root_r <= {root_r[OUT_W-2:0], 1'b1};
        end else begin
          rem_r  <= rem_sh[RW-1:0];
          root_r <= {root_r[OUT_W-2:0], 1'b0};
        end
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = root_r;
endmodule

>>> hdl/csm_div.sv
// ----------------------------------------------------------------------------
// csm_div
// iterative restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module csm_div import csm_pkg::*; #(
  parameter int N_W = 27,
  parameter int D_W = 17
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [N_W-1:0] numer,
  input  logic [D_W-1:0] denom,
  output logic           done,
  output logic [N_W-1:0] quot
);
  localparam int CW = $clog2(N_W + 1);
  logic [N_W-1:0] q_r;
  logic [D_W-1:0] d_r;
  logic [D_W:0]   rem_r;
  logic [CW-1:0]  cnt_r;
  logic           busy_r, done_r;
  logic [D_W+1:0] sh, diff;

  always_comb begin
    sh   = {rem_r, q_r[N_W-1]};
    diff = sh - {2'b00, d_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        q_r    <= numer;
        d_r    <= denom;
        rem_r  <= '0;
        cnt_r  <= CW'(N_W);
      end else if (busy_r) begin
        if (!diff[D_W+1]) begin
          rem_r <= diff[D_W:0];
          q_r   <= {q_r[N_W-2:0], 1'b1};
        end else begin
          rem_r <= sh[D_W:0];
          q_r   <= {q_r[N_W-2:0], 1'b0};
        end
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = q_r;
endmodule

>>> hdl/csm_vstore.sv
// ----------------------------------------------------------------------------
// csm_vstore
// vertex memory, one write and one registered read port
// ----------------------------------------------------------------------------
module csm_vstore import csm_pkg::*; #(
  parameter int DEPTH = 64,
  parameter int W = 48
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);
  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

>>> hdl/convex_support_mapping_checker.sv
// ----------------------------------------------------------------------------
// convex_support_mapping_checker
// port-level checks over time
// ----------------------------------------------------------------------------
module convex_support_mapping_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata,
  input logic [1:0]  out_tuser
);
  // an empty result carries zero data and no clip
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == '0 && !out_tuser[1])
    else $error("empty result not zero");
  // no result offered right after a reset cycle
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid) else $error("result offered after reset");
  // stalled result holds
  a_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");
endmodule

bind convex_support_mapping convex_support_mapping_checker u_chk (
  .clk(clk), .rst_n(rst_n), .out_tvalid(out_tvalid),
  .out_tready(out_tready), .out_tdata(out_tdata), .out_tuser(out_tuser)
);
